/* design/pd_source_cap_decode_and_select_core_assert.svh */
// assertion helpers for the source capability decoder
`ifndef PD_SOURCE_CAP_DECODE_AND_SELECT_CORE_ASSERT_SVH
`define PD_SOURCE_CAP_DECODE_AND_SELECT_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define PDSC_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdsc assertion failed");

// next-cycle implication, off during reset
`define PDSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdsc assertion failed");

`endif

/* design/pdsc_pkg.sv */
package pdsc_pkg;

    localparam int DEPTH   = 7;
    localparam int MAX_PDO = 7;
    localparam int CNT_W   = 3;

    // item kinds on the input tuser
    localparam logic [1:0] OP_HDR = 2'd0;
    localparam logic [1:0] OP_PDO = 2'd1;
    localparam logic [1:0] OP_REQ = 2'd2;

    // chosen supply kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_FIX  = 2'd1;
    localparam logic [1:0] KIND_PPS  = 2'd2;
    localparam logic [1:0] KIND_AVS  = 2'd3;

    // pdo type fields
    localparam logic [1:0] PDO_FIXED = 2'b00;
    localparam logic [1:0] PDO_APDO  = 2'b11;
    localparam logic [1:0] APDO_PPS  = 2'b00;
    localparam logic [1:0] APDO_AVS  = 2'b01;

    // reciprocal multipliers for divide by 1000, 100 and 25
    localparam logic [17:0] RECIP_FIX = 18'd67109;
    localparam logic [17:0] RECIP_PPS = 18'd167773;
    localparam logic [17:0] RECIP_AVS = 18'd167773;
    localparam int SH_FIX = 26;
    localparam int SH_PPS = 24;
    localparam int SH_AVS = 22;

    // search record that walks the cell chain
    typedef struct packed {
        logic        valid;
        logic [15:0] key;
        logic [15:0] key2;
        logic        fx_hit;
        logic        pps_hit;
        logic        avs_hit;
        logic [15:0] bf_d;
        logic [15:0] bf_mv;
        logic [15:0] bp_d;
        logic [15:0] bp_mv;
        logic [15:0] ba_d;
        logic [15:0] ba_mv;
    } scan_t;

    // table write broadcast to the cells
    typedef struct packed {
        logic        clr;
        logic        wr_fix;
        logic        wr_pps;
        logic        wr_avs;
        logic [15:0] fix_mv;
        logic [14:0] pps_lo;
        logic [14:0] pps_hi;
        logic [14:0] avs_lo;
        logic [15:0] avs_hi;
    } wr_t;

endpackage

/* design/pdsc_cell.sv */
module pdsc_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  pdsc_pkg::wr_t   wr,
    input  logic            sel,
    input  pdsc_pkg::scan_t rec_in,
    output pdsc_pkg::scan_t rec_out
);
    import pdsc_pkg::*;

    logic [15:0] fix_reg;
    logic [14:0] pps_lo_reg, pps_hi_reg, avs_lo_reg;
    logic [15:0] avs_hi_reg;
    logic        fv_reg, pv_reg, av_reg;
    scan_t       rec_reg, rec_next;

    function automatic logic [15:0] absdiff(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // entry storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
            pv_reg <= 1'b0;
            av_reg <= 1'b0;
        end else if (wr.clr) begin
            fv_reg <= 1'b0;
            pv_reg <= 1'b0;
            av_reg <= 1'b0;
        end else if (sel) begin
            if (wr.wr_fix) begin
                fv_reg  <= 1'b1;
                fix_reg <= wr.fix_mv;
            end
            if (wr.wr_pps) begin
                pv_reg     <= 1'b1;
                pps_lo_reg <= wr.pps_lo;
                pps_hi_reg <= wr.pps_hi;
            end
            if (wr.wr_avs) begin
                av_reg     <= 1'b1;
                avs_lo_reg <= wr.avs_lo;
                avs_hi_reg <= wr.avs_hi;
            end
        end
    end

    // compare this cell's entries against the passing record
    always_comb begin
        logic [15:0] d;
        d        = '0;
        rec_next = rec_in;
        if (fv_reg) begin
            if (fix_reg == rec_in.key2) rec_next.fx_hit = 1'b1;
            d = absdiff(rec_in.key, fix_reg);
            if (d < rec_next.bf_d) begin
                rec_next.bf_d  = d;
                rec_next.bf_mv = fix_reg;
            end
        end
        if (pv_reg) begin
            if (rec_in.key >= {1'b0, pps_lo_reg} && rec_in.key <= {1'b0, pps_hi_reg})
                rec_next.pps_hit = 1'b1;
            d = absdiff(rec_in.key, {1'b0, pps_lo_reg});
            if (d < rec_next.bp_d) begin
                rec_next.bp_d  = d;
                rec_next.bp_mv = {1'b0, pps_lo_reg};
            end
            d = absdiff(rec_in.key, {1'b0, pps_hi_reg});
            if (d < rec_next.bp_d) begin
                rec_next.bp_d  = d;
                rec_next.bp_mv = {1'b0, pps_hi_reg};
            end
        end
        if (av_reg) begin
            if (rec_in.key >= {1'b0, avs_lo_reg} && rec_in.key <= avs_hi_reg)
                rec_next.avs_hit = 1'b1;
            d = absdiff(rec_in.key, {1'b0, avs_lo_reg});
            if (d < rec_next.ba_d) begin
                rec_next.ba_d  = d;
                rec_next.ba_mv = {1'b0, avs_lo_reg};
            end
            d = absdiff(rec_in.key, avs_hi_reg);
            if (d < rec_next.ba_d) begin
                rec_next.ba_d  = d;
                rec_next.ba_mv = avs_hi_reg;
            end
        end
    end

    // hand the record to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg <= '0;
        end else begin
            rec_reg <= rec_next;
        end
    end

    assign rec_out = rec_reg;

endmodule

/* design/pd_source_cap_decode_and_select_core.sv */
// USB PD source capability decoder and voltage selector. A header transaction
// (tuser 0) with pd_active set clears the tables and arms up to seven objects;
// object transactions (tuser 1) are sorted into fixed, PPS and AVS tables held in
// a chain of seven cells, one table slot per cell. A request transaction
// (tuser 2) walks a search record down the chain twice: once to find an exact
// hit or nearest endpoint, once to check the chosen voltage for issue. Header
// and object transactions go straight to DONE and then to the output register; a
// request steps through SCAN1, MUL, QUO, SCAN2 and DONE (SCAN1 goes to DONE when
// nothing is found), each scan a pass through the seven registered cells. A new
// transaction is taken while the last result still waits in the output register.
module pd_source_cap_decode_and_select_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // word[31:0], pd_active[32], req_mv[48:33], zero fill above
    input  logic [55:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok[0], kind[2:1], chosen_mv[18:3], exact[19], issued[20], step_code[31:21],
    // fixed_count[34:32], pps_count[37:35], avs_count[40:38], zero fill above
    output logic [47:0] m_tdata
);
    import pdsc_pkg::*;
`include "pd_source_cap_decode_and_select_core_assert.svh"

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN1 = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_QUO   = 3'd3;
    localparam logic [2:0] ST_SCAN2 = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]       state_reg;
    logic [CNT_W-1:0] fix_cnt_reg, pps_cnt_reg, avs_cnt_reg, left_reg;
    logic             r_ok_reg, r_exact_reg, r_issued_reg;
    logic [1:0]       r_kind_reg;
    logic [15:0]      r_mv_reg;
    logic [10:0]      r_step_reg;
    logic [33:0]      prod_reg;
    logic [11:0]      q_reg;
    logic [40:0]      out_reg;
    logic             m_valid_reg;

    logic [1:0]  in_op;
    logic [31:0] in_word;
    logic        in_act;
    logic [15:0] in_req;
    logic        accept;
    logic [CNT_W-1:0] hdr_n;
    logic [11:0] q_w;
    logic        out_free;

    wr_t   wr;
    scan_t chain [DEPTH+1];
    logic [DEPTH-1:0] sel;

    // sel outcome from the first pass
    logic [1:0]  c_kind;
    logic [15:0] c_mv;
    logic        c_exact;
    logic [15:0] c_best;

    assign in_op   = s_tuser;
    assign in_word = s_tdata[31:0];
    assign in_act  = s_tdata[32];
    assign in_req  = s_tdata[48:33];

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign hdr_n    = (in_word[14:12] > CNT_W'(MAX_PDO)) ? CNT_W'(MAX_PDO) : in_word[14:12];

    function automatic logic v_allowed(input logic [11:0] v);
        return v == 12'd5 || v == 12'd9 || v == 12'd12 || v == 12'd15 ||
               v == 12'd20 || v == 12'd28;
    endfunction

    // object decode and table write
    always_comb begin
        logic pdo_ok;
        pdo_ok    = accept && (in_op == OP_PDO) && (left_reg != '0);
        wr.clr    = accept && (in_op == OP_HDR) && in_act;
        wr.wr_fix = pdo_ok && (in_word[31:30] == PDO_FIXED) && (fix_cnt_reg < CNT_W'(DEPTH));
        wr.wr_pps = pdo_ok && (in_word[31:30] == PDO_APDO) && (in_word[29:28] == APDO_PPS)
                    && (pps_cnt_reg < CNT_W'(DEPTH));
        wr.wr_avs = pdo_ok && (in_word[31:30] == PDO_APDO) && (in_word[29:28] == APDO_AVS)
                    && (avs_cnt_reg < CNT_W'(DEPTH));
        wr.fix_mv = 16'({6'd0, in_word[19:10]} * 16'd50);
        wr.pps_lo = 15'({7'd0, in_word[15:8]} * 15'd100);
        wr.pps_hi = 15'({7'd0, in_word[24:17]} * 15'd100);
        wr.avs_lo = 15'({7'd0, in_word[15:8]} * 15'd100);
        wr.avs_hi = 16'({7'd0, in_word[25:17]} * 16'd100);
    end

    // slot select per cell
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            sel[i] = (wr.wr_fix && fix_cnt_reg == CNT_W'(i)) ||
                     (wr.wr_pps && pps_cnt_reg == CNT_W'(i)) ||
                     (wr.wr_avs && avs_cnt_reg == CNT_W'(i));
        end
    end

    // quotient from the reciprocal product
    always_comb begin
        case (r_kind_reg)
            KIND_FIX: q_w = 12'(prod_reg >> SH_FIX);
            KIND_PPS: q_w = 12'(prod_reg >> SH_PPS);
            default:  q_w = 12'(prod_reg >> SH_AVS);
        endcase
    end

    // record injected at the head of the chain
    always_comb begin
        chain[0]       = '0;
        chain[0].bf_d  = 16'hFFFF;
        chain[0].bp_d  = 16'hFFFF;
        chain[0].ba_d  = 16'hFFFF;
        if (state_reg == ST_QUO) begin
            chain[0].valid = 1'b1;
            chain[0].key   = r_mv_reg;
            chain[0].key2  = 16'({4'd0, q_w} * 16'd1000);
        end else begin
            chain[0].valid = accept && (in_op == OP_REQ);
            chain[0].key   = in_req;
            chain[0].key2  = in_req;
        end
    end

    // row of table cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        pdsc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr      (wr),
            .sel     (sel[g]),
            .rec_in  (chain[g]),
            .rec_out (chain[g+1])
        );
    end

    // exact match priority, then nearest endpoint in scan order
    always_comb begin
        c_kind  = KIND_NONE;
        c_mv    = '0;
        c_exact = 1'b0;
        c_best  = 16'hFFFF;
        if (chain[DEPTH].fx_hit) begin
            c_kind = KIND_FIX;  c_mv = chain[DEPTH].key; c_exact = 1'b1;
        end else if (chain[DEPTH].pps_hit) begin
            c_kind = KIND_PPS;  c_mv = chain[DEPTH].key; c_exact = 1'b1;
        end else if (chain[DEPTH].avs_hit) begin
            c_kind = KIND_AVS;  c_mv = chain[DEPTH].key; c_exact = 1'b1;
        end else begin
            if (chain[DEPTH].bf_d < c_best) begin
                c_best = chain[DEPTH].bf_d; c_kind = KIND_FIX; c_mv = chain[DEPTH].bf_mv;
            end
            if (chain[DEPTH].bp_d < c_best) begin
                c_best = chain[DEPTH].bp_d; c_kind = KIND_PPS; c_mv = chain[DEPTH].bp_mv;
            end
            if (chain[DEPTH].ba_d < c_best) begin
                c_best = chain[DEPTH].ba_d; c_kind = KIND_AVS; c_mv = chain[DEPTH].ba_mv;
            end
        end
    end

    // control sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fix_cnt_reg <= '0;
            pps_cnt_reg <= '0;
            avs_cnt_reg <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        r_kind_reg   <= KIND_NONE;
                        r_mv_reg     <= '0;
                        r_exact_reg  <= 1'b0;
                        r_issued_reg <= 1'b0;
                        r_step_reg   <= '0;
                        if (in_op == OP_REQ) begin
                            r_ok_reg  <= 1'b0;
                            state_reg <= ST_SCAN1;
                        end else begin
                            state_reg <= ST_DONE;
                            if (wr.clr) begin
                                fix_cnt_reg <= '0;
                                pps_cnt_reg <= '0;
                                avs_cnt_reg <= '0;
                                left_reg    <= hdr_n;
                                r_ok_reg    <= 1'b1;
                            end else if (in_op == OP_PDO && left_reg != '0) begin
                                left_reg <= left_reg - 1'b1;
                                r_ok_reg <= wr.wr_fix || wr.wr_pps || wr.wr_avs;
                                if (wr.wr_fix) fix_cnt_reg <= fix_cnt_reg + 1'b1;
                                if (wr.wr_pps) pps_cnt_reg <= pps_cnt_reg + 1'b1;
                                if (wr.wr_avs) avs_cnt_reg <= avs_cnt_reg + 1'b1;
                            end else begin
                                r_ok_reg <= 1'b0;
                            end
                        end
                    end
                end
                ST_SCAN1: begin
                    if (chain[DEPTH].valid) begin
                        r_kind_reg  <= c_kind;
                        r_mv_reg    <= c_mv;
                        r_exact_reg <= c_exact;
                        state_reg   <= (c_kind == KIND_NONE) ? ST_DONE : ST_MUL;
                    end
                end
                ST_MUL: begin
                    case (r_kind_reg)
                        KIND_FIX: prod_reg <= r_mv_reg * RECIP_FIX;
                        KIND_PPS: prod_reg <= r_mv_reg * RECIP_PPS;
                        default:  prod_reg <= r_mv_reg * RECIP_AVS;
                    endcase
                    state_reg <= ST_QUO;
                end
                ST_QUO: begin
                    q_reg     <= q_w;
                    state_reg <= ST_SCAN2;
                end
                ST_SCAN2: begin
                    if (chain[DEPTH].valid) begin
                        r_ok_reg   <= 1'b1;
                        r_step_reg <= q_reg[10:0];
                        case (r_kind_reg)
                            KIND_FIX: r_issued_reg <= chain[DEPTH].fx_hit && v_allowed(q_reg);
                            KIND_PPS: r_issued_reg <= chain[DEPTH].pps_hit;
                            default:  r_issued_reg <= chain[DEPTH].avs_hit;
                        endcase
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            out_reg <= {avs_cnt_reg, pps_cnt_reg, fix_cnt_reg, r_step_reg, r_issued_reg,
                        r_exact_reg, r_mv_reg, r_kind_reg, r_ok_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_reg};

    `PDSC_ASSERT(a_chain_only_in_scan, aclk, aresetn, chain[DEPTH].valid,
                 (state_reg == ST_SCAN1) || (state_reg == ST_SCAN2))
    `PDSC_ASSERT(a_counts_bounded, aclk, aresetn, 1'b1,
                 (fix_cnt_reg <= CNT_W'(DEPTH)) && (pps_cnt_reg <= CNT_W'(DEPTH)) &&
                 (avs_cnt_reg <= CNT_W'(DEPTH)))
    `PDSC_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_tvalid && s_tready,
                      state_reg != ST_IDLE)
    `PDSC_ASSERT(a_kind_needs_ok, aclk, aresetn, m_tvalid,
                 m_tdata[0] || (m_tdata[2:1] == KIND_NONE))

endmodule
